// File: rtl/emh_pkg.sv
// ----------------------------------------------------------------------------
// emh_pkg
// Shared types and codes for the edge min-heap priority queue.
// ----------------------------------------------------------------------------
package emh_pkg;

  // Field widths of one edge
  localparam int COST_W  = 16;
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 9;

  // Command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One heap entry as held in the store
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } emh_entry_t;

  // One finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic [1:0]         status;
    logic [COST_W-1:0]  min_cost;
    logic [NODE_W-1:0]  min_node_a;
    logic [NODE_W-1:0]  min_node_b;
    logic [COUNT_W-1:0] entry_count;
  } emh_res_t;

endpackage

// File: rtl/emh_if.sv
// ----------------------------------------------------------------------------
// emh_in_if / emh_out_if
// Valid/ready channels for commands and results of the edge min-heap.
// ----------------------------------------------------------------------------
interface emh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [emh_pkg::COST_W-1:0] edge_cost;
  logic [emh_pkg::NODE_W-1:0] node_a;
  logic [emh_pkg::NODE_W-1:0] node_b;

  modport source (output valid, command, edge_cost, node_a, node_b, input ready);
  modport sink   (input valid, command, edge_cost, node_a, node_b, output ready);
endinterface

interface emh_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [emh_pkg::COST_W-1:0]  min_cost;
  logic [emh_pkg::NODE_W-1:0]  min_node_a;
  logic [emh_pkg::NODE_W-1:0]  min_node_b;
  logic [emh_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, min_cost, min_node_a, min_node_b, entry_count,
                  input ready);
  modport sink   (input valid, status, min_cost, min_node_a, min_node_b, entry_count,
                  output ready);
endinterface

// File: rtl/emh_mem.sv
// ----------------------------------------------------------------------------
// emh_mem
// Heap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module emh_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  emh_pkg::emh_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output emh_pkg::emh_entry_t rdata
);

  emh_pkg::emh_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/emh_ctrl.sv
// ----------------------------------------------------------------------------
// emh_ctrl
// Command sequencer: append and sift up, or pop root and sift down, one
// level at a time through the heap store. The moving entry stays in a
// register and is written once at its final slot.
// ----------------------------------------------------------------------------
module emh_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  emh_in_if.sink              in_ch,
  // heap store
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output emh_pkg::emh_entry_t mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  emh_pkg::emh_entry_t mem_rdata,
  // finished result
  output logic                res_valid,
  output emh_pkg::emh_res_t   res,
  input  logic                res_ready
);

  localparam int PW = CW + 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_EX_ROOT = 9'b000001000,
    S_EX_LAST = 9'b000010000,
    S_DN_RDL  = 9'b000100000,
    S_DN_RDR  = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  emh_pkg::emh_entry_t cur_r, cur_nxt;
  emh_pkg::emh_entry_t left_r, left_nxt;
  logic                has_right_r, has_right_nxt;
  emh_pkg::emh_res_t   res_r, res_nxt;

  logic [PW-1:0] lpos, rpos, count_w;
  logic [CW-1:0] parent;
  logic          left_win, right_win;
  logic [emh_pkg::COST_W-1:0] best_cost;

  // Child and parent positions of the hole
  assign lpos    = {pos_r, 1'b0};
  assign rpos    = {pos_r, 1'b1};
  assign count_w = PW'(count_r);
  assign parent  = pos_r >> 1;

  // Child selection: left wins ties, swap only on strictly smaller
  assign left_win  = left_r.cost < cur_r.cost;
  assign best_cost = left_win ? left_r.cost : cur_r.cost;
  assign right_win = has_right_r && (mem_rdata.cost < best_cost);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    has_right_nxt = has_right_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(pos_r - CW'(1));
    mem_wdata     = cur_r;
    mem_raddr     = '0;
    in_ch.ready   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          res_nxt        = '0;
          res_nxt.status = emh_pkg::ST_OK;
          if (in_ch.command == emh_pkg::CMD_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = emh_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              count_nxt      = count_r + CW'(1);
              pos_nxt        = count_r + CW'(1);
              cur_nxt.cost   = in_ch.edge_cost;
              cur_nxt.node_a = in_ch.node_a;
              cur_nxt.node_b = in_ch.node_b;
              state_nxt      = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = emh_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // read the root
              mem_raddr = '0;
              state_nxt = S_EX_ROOT;
            end
          end
        end
      end

      // Sift up: place at root, or fetch the parent
      S_UP_RD: begin
        if (pos_r == CW'(1)) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = AW'(parent - CW'(1));
          state_nxt = S_UP_CMP;
        end
      end

      // Move the parent down while it costs strictly more
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata.cost > cur_r.cost) begin
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Capture the root, fetch the last entry
      S_EX_ROOT: begin
        res_nxt.min_cost   = mem_rdata.cost;
        res_nxt.min_node_a = mem_rdata.node_a;
        res_nxt.min_node_b = mem_rdata.node_b;
        mem_raddr          = AW'(count_r - CW'(1));
        state_nxt          = S_EX_LAST;
      end

      // Last entry becomes the moving entry, hole at the root
      S_EX_LAST: begin
        cur_nxt   = mem_rdata;
        count_nxt = count_r - CW'(1);
        pos_nxt   = CW'(1);
        state_nxt = (count_r == CW'(1)) ? S_DONE : S_DN_RDL;
      end

      // Sift down: stop at a leaf, or fetch the left child
      S_DN_RDL: begin
        if (lpos > count_w) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr     = AW'(lpos - PW'(1));
          has_right_nxt = rpos <= count_w;
          state_nxt     = S_DN_RDR;
        end
      end

      // Hold the left child, fetch the right child
      S_DN_RDR: begin
        left_nxt  = mem_rdata;
        mem_raddr = AW'(rpos - PW'(1));
        state_nxt = S_DN_CMP;
      end

      // Move the smaller child up, or settle the entry here
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (right_win) begin
          mem_wdata = mem_rdata;
          pos_nxt   = CW'(rpos);
          state_nxt = S_DN_RDL;
        end else if (left_win) begin
          mem_wdata = left_r;
          pos_nxt   = CW'(lpos);
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Hand the result over
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    left_r      <= left_nxt;
    has_right_r <= has_right_nxt;
    res_r       <= res_nxt;
  end

  // Result with the count after the command
  always_comb begin
    res             = res_r;
    res.entry_count = emh_pkg::COUNT_W'(count_r);
  end
  assign res_valid = (state_r == S_DONE);

endmodule

// File: rtl/edge_min_heap_top.sv
// ----------------------------------------------------------------------------
// edge_min_heap_top
// Binary min-heap priority queue of graph edges keyed by cost.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    command, edge_cost, node_a, node_b
//   out_ch    out  valid/ready    status, min_cost, min_node_a, min_node_b,
//                                 entry_count
//
// One command at a time. Insert climbs one level per parent fetch and
// compare; extract fetches the root and the last entry, then descends one
// level per left-child fetch, right-child fetch and compare. Full or empty
// cases do not touch the store. The walk is paced by the single read port of
// the heap store, and an output register follows the sequencer. Reset clears
// the count, the sequencer state and the output valid; the store holds no
// valid bits.
// A stalled output holds its item in the output register while the next
// command is already taken and worked on; that command waits in its hand-off
// until the register drains.
// ----------------------------------------------------------------------------
module edge_min_heap_top #(
  parameter int CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  emh_in_if.sink    in_ch,
  emh_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  emh_pkg::emh_entry_t mem_wdata;
  emh_pkg::emh_entry_t mem_rdata;

  logic              res_valid;
  logic              res_ready;
  emh_pkg::emh_res_t res;

  logic              out_valid_r;
  emh_pkg::emh_res_t out_r;

  emh_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  emh_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  // Drive the result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.min_cost    = out_r.min_cost;
  assign out_ch.min_node_a  = out_r.min_node_a;
  assign out_ch.min_node_b  = out_r.min_node_b;
  assign out_ch.entry_count = out_r.entry_count;

endmodule
